// File: hw/rtl/vwd_pkg.sv
// vwd_pkg: shared types and constants for the vertex weld dedup block
package vwd_pkg;

    // fixed field widths of the transaction payloads
    localparam int IN_COORD_W  = 24;
    localparam int OUT_INDEX_W = 10;
    localparam int THR_W       = 50;

    // input transaction payload
    typedef struct packed {
        logic                         first_of_set;
        logic signed [IN_COORD_W-1:0] coord_x;
        logic signed [IN_COORD_W-1:0] coord_y;
        logic signed [IN_COORD_W-1:0] coord_z;
    } in_t;

    // result transaction payload
    typedef struct packed {
        logic [OUT_INDEX_W-1:0] vertex_index;
        logic                   is_new;
        logic                   store_full;
    } out_t;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUTPUT
    } state_t;

endpackage

// File: hw/rtl/vertex_weld_dedup.sv
// vertex_weld_dedup: streaming vertex welding against a store of unique vertices
//
//   channel | ports                     | payload
//   --------+---------------------------+-------------------------------------
//   input   | s_valid, s_ready, s_data  | first_of_set, coord_x/y/z
//   result  | m_valid, m_ready, m_data  | vertex_index, is_new, store_full
//   config  | cfg_wr_en, cfg_wr_data    | merge_threshold_sqr
//
// one vertex at a time; its scan is set by the single read port of the store, one entry
// compared per cycle, plus the distance pipeline (difference, square, sum, compare);
// a match ends the scan early.
// reset (aresetn, synchronous) empties the store count and zeroes the threshold.
// a result waiting on m_ready does not block the next input transaction; the
// scan of that next vertex holds in the output step until the result register frees.
module vertex_weld_dedup #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  vwd_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output vwd_pkg::out_t               m_data,
    input  logic                        cfg_wr_en,
    input  logic [vwd_pkg::THR_W-1:0]   cfg_wr_data
);

    localparam int CB     = COORD_BITS;
    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int EXT_W  = (CB > vwd_pkg::IN_COORD_W) ? CB : vwd_pkg::IN_COORD_W;
    localparam int OIW    = vwd_pkg::OUT_INDEX_W;

    vwd_pkg::state_t            state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           issue_cnt_reg, issue_cnt_next;
    logic [CNT_W-1:0]           res_cnt_reg, res_cnt_next;
    logic [3*CB-1:0]            vertex_reg, vertex_next;
    logic [vwd_pkg::THR_W-1:0]  thr_reg;
    vwd_pkg::out_t              rslt_reg, rslt_next;
    vwd_pkg::out_t              m_data_reg, m_data_next;
    logic                       m_valid_reg, m_valid_next;

    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;
    logic [IDX_W-1:0]           mem_raddr;
    logic [3*CB-1:0]            mem_rdata;
    logic                       issue_valid;
    logic                       flush;
    logic                       res_valid;
    logic                       res_match;
    logic                       dist_busy;
    logic [3*CB-1:0]            in_vertex;

    // entry number masked to the result index width
    function automatic logic [OIW-1:0] to_index(input logic [CNT_W-1:0] n);
        logic [CNT_W+OIW-1:0] w;
        w = {{OIW{1'b0}}, n};
        return w[OIW-1:0];
    endfunction

    // coordinates taken as COORD_BITS-bit two's complement
    always_comb begin
        logic signed [EXT_W-1:0] ex;
        logic signed [EXT_W-1:0] ey;
        logic signed [EXT_W-1:0] ez;
        ex = EXT_W'(s_data.coord_x);
        ey = EXT_W'(s_data.coord_y);
        ez = EXT_W'(s_data.coord_z);
        in_vertex = {ex[CB-1:0], ey[CB-1:0], ez[CB-1:0]};
    end

    // unique vertex store
    vwd_store #(
        .DEPTH  (MAX_VERTICES),
        .DATA_W (3 * CB),
        .ADDR_W (IDX_W)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (vertex_reg),
        .re    (issue_valid),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // distance compare pipeline
    vwd_dist #(
        .COORD_BITS (CB)
    ) u_dist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .issue_valid (issue_valid),
        .flush       (flush),
        .vertex      (vertex_reg),
        .entry       (mem_rdata),
        .threshold   (thr_reg),
        .res_valid   (res_valid),
        .res_match   (res_match),
        .busy        (dist_busy)
    );

    assign mem_waddr = count_reg[IDX_W-1:0];
    assign mem_raddr = issue_cnt_reg[IDX_W-1:0];

    // sequencer: scan issue, match/miss decision, append, result handoff
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_cnt_next = issue_cnt_reg;
        res_cnt_next   = res_cnt_reg;
        vertex_next    = vertex_reg;
        rslt_next      = rslt_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg;
        s_ready        = 1'b0;
        mem_we         = 1'b0;
        issue_valid    = 1'b0;
        flush          = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            vwd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    vertex_next    = in_vertex;
                    count_next     = s_data.first_of_set ? '0 : count_reg;
                    issue_cnt_next = '0;
                    res_cnt_next   = '0;
                    state_next     = vwd_pkg::ST_SCAN;
                end
            end
            vwd_pkg::ST_SCAN: begin
                // one store read per cycle, in store order
                if (issue_cnt_reg < count_reg) begin
                    issue_valid    = 1'b1;
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                if (res_valid) begin
                    res_cnt_next = res_cnt_reg + CNT_W'(1);
                    // results come back in order, so the first match is the lowest entry
                    if (res_match) begin
                        rslt_next.vertex_index = to_index(res_cnt_reg);
                        rslt_next.is_new       = 1'b0;
                        rslt_next.store_full   = 1'b0;
                        flush                  = 1'b1;
                        state_next             = vwd_pkg::ST_OUTPUT;
                    end
                end else if (issue_cnt_reg == count_reg && !dist_busy) begin
                    // no match: append, or drop when the store is full
                    if (count_reg < CNT_W'(MAX_VERTICES)) begin
                        mem_we                 = 1'b1;
                        count_next             = count_reg + CNT_W'(1);
                        rslt_next.vertex_index = to_index(count_reg);
                        rslt_next.is_new       = 1'b1;
                        rslt_next.store_full   = 1'b0;
                    end else begin
                        rslt_next.vertex_index = '0;
                        rslt_next.is_new       = 1'b0;
                        rslt_next.store_full   = 1'b1;
                    end
                    state_next = vwd_pkg::ST_OUTPUT;
                end
            end
            vwd_pkg::ST_OUTPUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = rslt_reg;
                    m_valid_next = 1'b1;
                    state_next   = vwd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vwd_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= vwd_pkg::ST_IDLE;
            count_reg     <= '0;
            issue_cnt_reg <= '0;
            res_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
            thr_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_cnt_reg <= issue_cnt_next;
            res_cnt_reg   <= res_cnt_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        vertex_reg <= vertex_next;
        rslt_reg   <= rslt_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks on the sequencer
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_VERTICES))
        else $error("unique count beyond store depth");

    a_append_room: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (count_reg < CNT_W'(MAX_VERTICES)) && !dist_busy)
        else $error("append with full store or reads in flight");

    a_issue_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_valid |-> (state_reg == vwd_pkg::ST_SCAN) && (issue_cnt_reg < count_reg))
        else $error("store read outside the scan range");

    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.store_full) |->
            (!m_data.is_new && (m_data.vertex_index == '0)))
        else $error("full result carries an index or new flag");

    a_result_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == vwd_pkg::ST_OUTPUT))
        else $error("result raised without a finished scan");

endmodule

// File: hw/rtl/vwd_store.sv
// vwd_store: unique vertex memory, one write port and one registered read port
module vwd_store #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 72,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/vwd_dist.sv
// vwd_dist: pipelined squared distance compare of one stored entry per cycle
module vwd_dist #(
    parameter int COORD_BITS = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    issue_valid,
    input  logic                    flush,
    input  logic [3*COORD_BITS-1:0] vertex,
    input  logic [3*COORD_BITS-1:0] entry,
    input  logic [vwd_pkg::THR_W-1:0] threshold,
    output logic                    res_valid,
    output logic                    res_match,
    output logic                    busy
);

    localparam int CB    = COORD_BITS;
    localparam int SQ_W  = 2 * CB;
    localparam int SUM_W = SQ_W + 2;
    localparam int CMP_W = (SUM_W > vwd_pkg::THR_W) ? SUM_W : vwd_pkg::THR_W;

    logic              v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic [CB-1:0]     ad_reg   [3];
    logic [CB-1:0]     ad_next  [3];
    logic [SQ_W-1:0]   sq_reg   [3];
    logic [SUM_W-1:0]  sum_reg;
    logic              match_reg;
    logic [CMP_W-1:0]  sum_ext;
    logic [CMP_W-1:0]  thr_ext;

    // per-axis absolute difference, one bit wider before the magnitude
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [CB-1:0] a;
            logic signed [CB-1:0] b;
            logic signed [CB:0]   d;
            logic [CB:0]          m;
            a = vertex[(2-k)*CB +: CB];
            b = entry[(2-k)*CB +: CB];
            d = {a[CB-1], a} - {b[CB-1], b};
            m = d[CB] ? (~d + (CB+1)'(1)) : d;
            ad_next[k] = m[CB-1:0];
        end
    end

    assign sum_ext = CMP_W'(sum_reg);
    assign thr_ext = CMP_W'(threshold);

    // valid tags, cleared on flush
    always_ff @(posedge aclk) begin
        if (!aresetn || flush) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v0_reg <= issue_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // datapath: difference, square, sum, compare
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            ad_reg[k] <= ad_next[k];
            sq_reg[k] <= SQ_W'(ad_reg[k]) * SQ_W'(ad_reg[k]);
        end
        sum_reg   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        match_reg <= (sum_ext <= thr_ext);
    end

    assign res_valid = v4_reg;
    assign res_match = match_reg;
    assign busy      = v0_reg | v1_reg | v2_reg | v3_reg | v4_reg;

endmodule

// File: verif/vertex_weld_dedup_test.sv
// vertex_weld_dedup_test: self-checking testbench for the vertex weld dedup block
`timescale 1ns / 1ps

module vertex_weld_dedup_test;

    localparam int STORE_DEPTH = 1024;
    localparam int DRAIN_PAUSE = 16;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_REPORTS = 100;

    localparam logic signed [vwd_pkg::IN_COORD_W-1:0] COORD_MAX =
        {1'b0, {(vwd_pkg::IN_COORD_W-1){1'b1}}};
    localparam logic signed [vwd_pkg::IN_COORD_W-1:0] COORD_MIN =
        {1'b1, {(vwd_pkg::IN_COORD_W-1){1'b0}}};

    // block ports
    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    vwd_pkg::in_t                s_data      = '0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    vwd_pkg::out_t               m_data;
    logic                        cfg_wr_en   = 1'b0;
    logic [vwd_pkg::THR_W-1:0]   cfg_wr_data = '0;

    // predicted store of unique vertices and the merge threshold
    logic signed [vwd_pkg::IN_COORD_W-1:0] weld_x [STORE_DEPTH];
    logic signed [vwd_pkg::IN_COORD_W-1:0] weld_y [STORE_DEPTH];
    logic signed [vwd_pkg::IN_COORD_W-1:0] weld_z [STORE_DEPTH];
    int                                    unique_total = 0;
    logic [vwd_pkg::THR_W-1:0]             merge_thr    = '0;

    // expected weld results, oldest first
    vwd_pkg::out_t expected_welds[$];

    int error_count       = 0;
    int hold_off_request  = 0;
    bit steady_flow       = 1'b0;

    vertex_weld_dedup #(
        .MAX_VERTICES (STORE_DEPTH),
        .COORD_BITS   (vwd_pkg::IN_COORD_W)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // squared difference along one axis
    function automatic longint unsigned axis_sq(
        input logic signed [vwd_pkg::IN_COORD_W-1:0] a, b);
        longint d;
        d = longint'(a) - longint'(b);
        return longint'(d * d);
    endfunction

    // weld one vertex against the predicted store, updating it
    function automatic vwd_pkg::out_t weld_vertex(input vwd_pkg::in_t v);
        vwd_pkg::out_t   r;
        int              hit;
        longint unsigned sq_dist;
        r = '0;
        hit = -1;
        if (v.first_of_set) begin
            unique_total = 0;
        end
        for (int i = 0; i < unique_total && hit < 0; i++) begin
            sq_dist = axis_sq(v.coord_x, weld_x[i]) + axis_sq(v.coord_y, weld_y[i])
                    + axis_sq(v.coord_z, weld_z[i]);
            if (sq_dist <= 64'(merge_thr)) begin
                hit = i;
            end
        end
        if (hit >= 0) begin
            r.vertex_index = vwd_pkg::OUT_INDEX_W'(hit);
        end else if (unique_total < STORE_DEPTH) begin
            weld_x[unique_total] = v.coord_x;
            weld_y[unique_total] = v.coord_y;
            weld_z[unique_total] = v.coord_z;
            r.vertex_index = vwd_pkg::OUT_INDEX_W'(unique_total);
            r.is_new = 1'b1;
            unique_total++;
        end else begin
            r.store_full = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        error_count++;
    endtask

    // offer one vertex after a random gap, record its expected result on acceptance
    task automatic send_vertex(input logic first,
                               input logic signed [vwd_pkg::IN_COORD_W-1:0] x, y, z);
        vwd_pkg::in_t item;
        int           gap;
        item = '{first_of_set: first, coord_x: x, coord_y: y, coord_z: z};
        gap = steady_flow ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        expected_welds = {expected_welds, weld_vertex(item)};
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_welds.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAUSE) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [vwd_pkg::THR_W-1:0] thr);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= thr;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        merge_thr = thr;
    endtask

    // result receiver: random stalls after each transaction, long hold on request
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_request > 0) begin
                stall = hold_off_request;
                hold_off_request = 0;
            end else if (m_valid && m_ready) begin
                stall = steady_flow ? 0 : $urandom_range(0, 4);
            end else if (stall > 0) begin
                stall--;
            end
            m_ready <= (stall == 0);
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin : result_check
        vwd_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_welds.size() == 0) begin
                report_mismatch($sformatf("unexpected result index %0d", m_data.vertex_index));
            end else begin
                want = expected_welds.pop_front();
                if (m_data.vertex_index !== want.vertex_index) begin
                    report_mismatch($sformatf("vertex_index got %0d want %0d",
                                              m_data.vertex_index, want.vertex_index));
                end
                if (m_data.is_new !== want.is_new) begin
                    report_mismatch($sformatf("is_new got %b want %b",
                                              m_data.is_new, want.is_new));
                end
                if (m_data.store_full !== want.store_full) begin
                    report_mismatch($sformatf("store_full got %b want %b",
                                              m_data.store_full, want.store_full));
                end
            end
        end
    end

    // exact matching at the reset threshold, coordinate extremes, set restart
    task automatic test_exact_match();
        send_vertex(1'b1, 0, 0, 0);
        send_vertex(1'b0, 0, 0, 0);
        send_vertex(1'b0, 1, 0, 0);
        send_vertex(1'b0, 0, 0, 1);
        send_vertex(1'b0, COORD_MAX, COORD_MAX, COORD_MAX);
        send_vertex(1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
        send_vertex(1'b0, COORD_MIN, COORD_MAX, -1);
        send_vertex(1'b0, COORD_MAX, COORD_MAX, COORD_MAX);
        send_vertex(1'b0, -1, -1, -1);
        send_vertex(1'b1, 1, 0, 0);
    endtask

    // widest threshold merges everything, boundary distance, first of a cluster wins
    task automatic test_threshold_edges();
        write_threshold('1);
        send_vertex(1'b1, COORD_MIN, COORD_MIN, COORD_MIN);
        send_vertex(1'b0, COORD_MAX, COORD_MAX, COORD_MAX);
        send_vertex(1'b0, 0, 0, 0);
        write_threshold(vwd_pkg::THR_W'(25));
        send_vertex(1'b1, 0, 0, 0);
        send_vertex(1'b0, 3, 4, 0);
        send_vertex(1'b0, 3, 4, 1);
        send_vertex(1'b0, 6, 0, 0);
        send_vertex(1'b0, 3, 0, 0);
        send_vertex(1'b0, -3, -4, 0);
    endtask

    // fill the store, then probe matches at both ends and drops when full
    task automatic test_store_full();
        logic signed [vwd_pkg::IN_COORD_W-1:0] y0, z0, yl, zl, y, z;
        y0 = '0;
        z0 = '0;
        yl = '0;
        zl = '0;
        write_threshold('0);
        for (int i = 0; i < STORE_DEPTH; i++) begin
            y = vwd_pkg::IN_COORD_W'($urandom);
            z = vwd_pkg::IN_COORD_W'($urandom);
            if (i == 0) begin
                y0 = y;
                z0 = z;
            end
            yl = y;
            zl = z;
            send_vertex(i == 0, vwd_pkg::IN_COORD_W'(i), y, z);
        end
        send_vertex(1'b0, 0, y0, z0);
        send_vertex(1'b0, vwd_pkg::IN_COORD_W'(STORE_DEPTH - 1), yl, zl);
        send_vertex(1'b0, -5, 0, 0);
        send_vertex(1'b0, COORD_MAX, COORD_MIN, COORD_MAX);
        send_vertex(1'b1, -5, 0, 0);
    endtask

    // hold the result side so the block fills and stalls its input
    task automatic test_backpressure();
        wait_drained();
        hold_off_request = LONG_HOLD;
        send_vertex(1'b1, 10, 20, 30);
        for (int i = 0; i < 7; i++) begin
            if (i[0]) begin
                send_vertex(1'b0, 10, 20, 30);
            end else begin
                send_vertex(1'b0, vwd_pkg::IN_COORD_W'($urandom),
                            vwd_pkg::IN_COORD_W'($urandom),
                            vwd_pkg::IN_COORD_W'($urandom));
            end
        end
        wait_drained();
    endtask

    // random sets with repeats and near neighbors under several thresholds
    task automatic test_random_sets();
        vwd_pkg::in_t                          history[$];
        vwd_pkg::in_t                          pick;
        logic [vwd_pkg::THR_W-1:0]             thr;
        logic signed [vwd_pkg::IN_COORD_W-1:0] x, y, z;
        int                                    set_left;
        int                                    kind;
        logic                                  first;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    thr = '0;
                end
                1: begin
                    thr = vwd_pkg::THR_W'($urandom_range(0, 20000));
                end
                2: begin
                    thr = vwd_pkg::THR_W'({$urandom, $urandom});
                end
                3: begin
                    thr = '1;
                end
                default: begin
                    thr = vwd_pkg::THR_W'($urandom_range(1, 4096));
                end
            endcase
            write_threshold(thr);
            steady_flow = (phase == 1);
            set_left = 0;
            for (int n = 0; n < 100; n++) begin
                first = (set_left == 0);
                if (first) begin
                    history.delete();
                    set_left = $urandom_range(1, 40);
                end
                set_left--;
                kind = $urandom_range(0, 9);
                if (history.size() == 0 || kind < 3) begin
                    x = vwd_pkg::IN_COORD_W'($urandom);
                    y = vwd_pkg::IN_COORD_W'($urandom);
                    z = vwd_pkg::IN_COORD_W'($urandom);
                end else if (kind == 9) begin
                    x = vwd_pkg::IN_COORD_W'($urandom_range(0, 6) - 3);
                    y = vwd_pkg::IN_COORD_W'($urandom_range(0, 6) - 3);
                    z = vwd_pkg::IN_COORD_W'($urandom_range(0, 6) - 3);
                end else begin
                    pick = history[$urandom_range(0, history.size() - 1)];
                    x = pick.coord_x;
                    y = pick.coord_y;
                    z = pick.coord_z;
                    // nudge within a small neighborhood
                    if (kind >= 6) begin
                        x = x + vwd_pkg::IN_COORD_W'($urandom_range(0, 128) - 64);
                        y = y + vwd_pkg::IN_COORD_W'($urandom_range(0, 128) - 64);
                        z = z + vwd_pkg::IN_COORD_W'($urandom_range(0, 128) - 64);
                    end
                end
                send_vertex(first, x, y, z);
                history = {history, vwd_pkg::in_t'{first_of_set: first, coord_x: x,
                                                   coord_y: y, coord_z: z}};
            end
            steady_flow = 1'b0;
        end
    endtask

    // test sequence
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_exact_match();
        test_threshold_edges();
        test_store_full();
        test_backpressure();
        test_random_sets();
        wait_drained();
        if (error_count == 0) begin
            $display("vertex_weld_dedup verification clean");
        end else begin
            $display("vertex_weld_dedup verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #8000000;
        $display("vertex_weld_dedup verification failed");
        $finish;
    end

endmodule
